[rtl/jst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and codes for the JSON subset tokenizer: word layouts, event
// and error codes, and the characters the parser reacts to.
// ----------------------------------------------------------------------------
package jst_pkg;

    localparam int BYTE_W  = 8;
    localparam int DEPTH_W = 8;
    localparam int RUN_W   = 16;
    localparam int KIND_W  = 3;
    localparam int CODE_W  = 3;

    localparam logic [RUN_W-1:0] DEFAULT_MAX_RUN = 16'd512;
    localparam logic [RUN_W-1:0] RUN_SAT         = 16'hFFFF;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [KIND_W-1:0] EV_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] EV_KEY      = 3'd1;
    localparam logic [KIND_W-1:0] EV_KEY_END  = 3'd2;
    localparam logic [KIND_W-1:0] EV_STR      = 3'd3;
    localparam logic [KIND_W-1:0] EV_DIGIT    = 3'd4;
    localparam logic [KIND_W-1:0] EV_PAIR_END = 3'd5;
    localparam logic [KIND_W-1:0] EV_DOC_OK   = 3'd6;
    localparam logic [KIND_W-1:0] EV_DOC_ERR  = 3'd7;

    localparam logic [CODE_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [CODE_W-1:0] ERR_UNEXPECTED = 3'd1;
    localparam logic [CODE_W-1:0] ERR_DEPTH_NEG  = 3'd2;
    localparam logic [CODE_W-1:0] ERR_RUN_LONG   = 3'd3;
    localparam logic [CODE_W-1:0] ERR_INCOMPLETE = 3'd4;
    localparam logic [CODE_W-1:0] ERR_TOO_DEEP   = 3'd5;

    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] text_byte;
    } in_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [BYTE_W-1:0]  event_byte;
        logic [CODE_W-1:0]  error_code;
        logic [DEPTH_W-1:0] nesting_depth;
    } out_word_t;

endpackage

`default_nettype wire

[rtl/jst_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jst_in_if
// Text channel: one text byte or end-of-text mark per word.
// ----------------------------------------------------------------------------
interface jst_in_if;

    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] text_byte;

    modport source (output valid, output action, output text_byte, input ready);
    modport sink   (input valid, input action, input text_byte, output ready);

endinterface

`default_nettype wire

[rtl/jst_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jst_out_if
// Event channel: one tokenizer event per word.
// ----------------------------------------------------------------------------
interface jst_out_if;

    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] event_byte;
    logic [2:0] error_code;
    logic [7:0] nesting_depth;

    modport source (output valid, output event_kind, output event_byte,
                    output error_code, output nesting_depth, input ready);
    modport sink   (input valid, input event_kind, input event_byte,
                    input error_code, input nesting_depth, output ready);

endinterface

`default_nettype wire

[rtl/jst_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jst_in_stage
// Input register: captures one text word and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module jst_in_stage
    import jst_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     up_valid,
    output logic          up_ready,
    input  wire in_word_t up_word,
    input  wire logic     advance,
    output logic          word_valid,
    output in_word_t      word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     take;

    assign up_ready = !valid_reg || advance;
    assign take     = up_valid && up_ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= up_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

[rtl/jst_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jst_core
// Parse state machine: nine-state position, escape flag, depth, run counter
// and sticky failure code, updated once per consumed word.
// ----------------------------------------------------------------------------
module jst_core
    import jst_pkg::*;
#(
    parameter int MAX_DEPTH = 255
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire in_word_t          word,
    input  wire logic [RUN_W-1:0]  max_run,
    output out_word_t              result
);

    localparam int DEPTH_LIMIT = (MAX_DEPTH > 255) ? 255 : MAX_DEPTH;
    localparam logic [DEPTH_W:0] DEPTH_LIMIT_W = (DEPTH_W + 1)'(DEPTH_LIMIT);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_LEFT,
        ST_KEY_QUOTE,
        ST_KEY_RIGHT,
        ST_VALUE_LEFT,
        ST_VALUE_NUM,
        ST_VALUE_QUOTE,
        ST_VALUE_RIGHT,
        ST_PAIR_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               esc_reg;
    logic               esc_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [RUN_W-1:0]   run_reg;
    logic [RUN_W-1:0]   run_next;
    logic [CODE_W-1:0]  failed_reg;
    logic [CODE_W-1:0]  failed_next;

    state_t             nxt;
    logic [DEPTH_W:0]   depth_w;
    logic               esc_w;
    logic [CODE_W-1:0]  fail;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  ebyte;
    logic [BYTE_W-1:0]  c;
    logic               is_digit;
    logic               is_closer;
    logic               doc_ok;

    // transition decision for a text byte
    always_comb
    begin
        c         = word.text_byte;
        is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_closer = (c == CH_RBRACE) || (c == CH_RBRACK);
        nxt       = state_reg;
        depth_w   = {1'b0, depth_reg};
        esc_w     = esc_reg;
        fail      = ERR_NONE;
        kind      = EV_NONE;
        ebyte     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (c == CH_LBRACE)
                begin
                    nxt     = ST_KEY_LEFT;
                    depth_w = depth_w + 1'b1;
                end
                else
                begin
                    fail = ERR_UNEXPECTED;
                end
            end
            ST_KEY_LEFT:
            begin
                if ((c == CH_LBRACE) || (c == CH_LBRACK))
                begin
                    depth_w = depth_w + 1'b1;
                end
                else if (c == CH_RBRACE)
                begin
                    if (depth_reg == '0)
                    begin
                        fail = ERR_DEPTH_NEG;
                    end
                    else
                    begin
                        depth_w = depth_w - 1'b1;
                    end
                end
                else if (c == CH_QUOTE)
                begin
                    nxt = ST_KEY_QUOTE;
                end
                else
                begin
                    fail = ERR_UNEXPECTED;
                end
            end
            ST_PAIR_FINISH:
            begin
                if (is_closer)
                begin
                    if (depth_reg == '0)
                    begin
                        fail = ERR_DEPTH_NEG;
                    end
                    else
                    begin
                        depth_w = depth_w - 1'b1;
                    end
                end
                else if (c == CH_QUOTE)
                begin
                    nxt = ST_KEY_QUOTE;
                end
                else if (c == CH_COMMA)
                begin
                    nxt = ST_KEY_LEFT;
                end
                else
                begin
                    fail = ERR_UNEXPECTED;
                end
            end
            ST_KEY_QUOTE,
            ST_VALUE_QUOTE:
            begin
                if (esc_reg)
                begin
                    esc_w = 1'b0;
                    kind  = (state_reg == ST_KEY_QUOTE) ? EV_KEY : EV_STR;
                    ebyte = c;
                end
                else if (c == CH_QUOTE)
                begin
                    if (state_reg == ST_KEY_QUOTE)
                    begin
                        nxt  = ST_KEY_RIGHT;
                        kind = EV_KEY_END;
                    end
                    else
                    begin
                        nxt = ST_VALUE_RIGHT;
                    end
                end
                else if (c == CH_BSLASH)
                begin
                    esc_w = 1'b1;
                end
                else
                begin
                    kind  = (state_reg == ST_KEY_QUOTE) ? EV_KEY : EV_STR;
                    ebyte = c;
                end
            end
            ST_KEY_RIGHT:
            begin
                if (c == CH_COLON)
                begin
                    nxt = ST_VALUE_LEFT;
                end
                else
                begin
                    fail = ERR_UNEXPECTED;
                end
            end
            ST_VALUE_LEFT:
            begin
                if ((c == CH_LBRACE) || (c == CH_LBRACK))
                begin
                    nxt     = ST_KEY_LEFT;
                    depth_w = depth_w + 1'b1;
                end
                else if (c == CH_QUOTE)
                begin
                    nxt = ST_VALUE_QUOTE;
                end
                else if (is_digit)
                begin
                    nxt   = ST_VALUE_NUM;
                    kind  = EV_DIGIT;
                    ebyte = c;
                end
                else
                begin
                    fail = ERR_UNEXPECTED;
                end
            end
            ST_VALUE_NUM,
            ST_VALUE_RIGHT:
            begin
                if (is_digit && (state_reg == ST_VALUE_NUM))
                begin
                    kind  = EV_DIGIT;
                    ebyte = c;
                end
                else if (is_closer)
                begin
                    if (depth_reg == '0)
                    begin
                        fail = ERR_DEPTH_NEG;
                    end
                    else
                    begin
                        depth_w = depth_w - 1'b1;
                        nxt     = ST_PAIR_FINISH;
                        kind    = EV_PAIR_END;
                    end
                end
                else if (c == CH_COMMA)
                begin
                    nxt  = ST_PAIR_FINISH;
                    kind = EV_PAIR_END;
                end
                else
                begin
                    fail = ERR_UNEXPECTED;
                end
            end
            default:
            begin
                fail = ERR_UNEXPECTED;
            end
        endcase

        if ((fail == ERR_NONE) && (depth_w > DEPTH_LIMIT_W))
        begin
            fail = ERR_TOO_DEEP;
        end
        if ((fail == ERR_NONE) && (nxt == state_reg) && (run_reg >= max_run))
        begin
            fail = ERR_RUN_LONG;
        end
    end

    // result word and next register values
    always_comb
    begin
        doc_ok = (failed_reg == ERR_NONE) && (depth_reg == '0) &&
                 ((state_reg == ST_IDLE) || (state_reg == ST_PAIR_FINISH));

        state_next  = state_reg;
        esc_next    = esc_reg;
        depth_next  = depth_reg;
        run_next    = run_reg;
        failed_next = failed_reg;

        result.event_kind    = EV_NONE;
        result.event_byte    = '0;
        result.error_code    = ERR_NONE;
        result.nesting_depth = depth_reg;

        if (word.action == ACT_END)
        begin
            result.event_kind    = doc_ok ? EV_DOC_OK : EV_DOC_ERR;
            result.error_code    = doc_ok ? ERR_NONE :
                                   ((failed_reg != ERR_NONE) ? failed_reg : ERR_INCOMPLETE);
            result.nesting_depth = '0;
            state_next  = ST_IDLE;
            esc_next    = 1'b0;
            depth_next  = '0;
            run_next    = '0;
            failed_next = ERR_NONE;
        end
        else if (failed_reg != ERR_NONE)
        begin
            result.error_code = failed_reg;
        end
        else if (fail != ERR_NONE)
        begin
            result.event_kind = EV_DOC_ERR;
            result.error_code = fail;
            failed_next       = fail;
        end
        else
        begin
            result.event_kind    = kind;
            result.event_byte    = ebyte;
            result.nesting_depth = depth_w[DEPTH_W-1:0];
            state_next = nxt;
            esc_next   = esc_w;
            depth_next = depth_w[DEPTH_W-1:0];
            if (nxt == state_reg)
            begin
                run_next = (run_reg == RUN_SAT) ? run_reg : run_reg + 1'b1;
            end
            else
            begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            esc_reg    <= 1'b0;
            depth_reg  <= '0;
            run_reg    <= '0;
            failed_reg <= ERR_NONE;
        end
        else if (step_en)
        begin
            state_reg  <= state_next;
            esc_reg    <= esc_next;
            depth_reg  <= depth_next;
            run_reg    <= run_next;
            failed_reg <= failed_next;
        end
    end

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (word.action == ACT_BYTE) && (failed_reg != ERR_NONE)
        |=> failed_reg == $past(failed_reg))
        else $error("failure code changed before end of text");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (word.action == ACT_END)
        |=> (state_reg == ST_IDLE) && (depth_reg == '0) && (failed_reg == ERR_NONE)
            && !esc_reg && (run_reg == '0))
        else $error("parser not cleared after end of text");

    a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, depth_reg} <= DEPTH_LIMIT_W)
        else $error("depth above limit");

    a_esc_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (state_reg == ST_KEY_QUOTE) || (state_reg == ST_VALUE_QUOTE))
        else $error("escape pending outside a string");

endmodule

`default_nettype wire

[rtl/jst_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jst_out_stage
// Result register: holds one event word until the downstream side takes it.
// ----------------------------------------------------------------------------
module jst_out_stage
    import jst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_word_t load_word,
    output logic           advance,
    output logic           down_valid,
    input  wire logic      down_ready,
    output out_word_t      down_word
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    assign advance = !valid_reg || down_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign down_valid = valid_reg;
    assign down_word  = word_reg;

endmodule

`default_nettype wire

[rtl/json_subset_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_subset_tokenizer
// Byte-serial tokenizer for a whitespace-free JSON subset.
// ----------------------------------------------------------------------------
// Takes one text byte or end-of-text mark per word on byte_ch and returns
// exactly one event word on event_ch for each: no event, key byte, key end,
// string byte, digit, pair end, error, or document ok/error at end of text,
// after which the parser is back at its reset state. Throughput is one word
// per clock while the event side accepts; the parse state registers update
// once per word. The event word passes through the input register, then
// the result register; a stalled event side holds the result register and,
// with the input register full, drops byte_ch.ready in the same cycle.
// max_run is written through cfg_we and cfg_wdata and resets to 512; the user
// must write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module json_subset_tokenizer
    import jst_pkg::*;
#(
    parameter int MAX_DEPTH = 255
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    jst_in_if.sink           byte_ch,
    jst_out_if.source        event_ch
);

    logic [RUN_W-1:0] max_run_reg;
    in_word_t         up_word;
    in_word_t         word;
    logic             word_valid;
    logic             advance;
    logic             step_en;
    out_word_t        result;
    out_word_t        down_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_reg <= DEFAULT_MAX_RUN;
        end
        else if (cfg_we)
        begin
            max_run_reg <= cfg_wdata;
        end
    end

    assign up_word.action    = byte_ch.action;
    assign up_word.text_byte = byte_ch.text_byte;
    assign step_en           = word_valid && advance;

    jst_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (byte_ch.valid),
        .up_ready   (byte_ch.ready),
        .up_word    (up_word),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    jst_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .word    (word),
        .max_run (max_run_reg),
        .result  (result)
    );

    jst_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step_en),
        .load_word  (result),
        .advance    (advance),
        .down_valid (event_ch.valid),
        .down_ready (event_ch.ready),
        .down_word  (down_word)
    );

    assign event_ch.event_kind    = down_word.event_kind;
    assign event_ch.event_byte    = down_word.event_byte;
    assign event_ch.error_code    = down_word.error_code;
    assign event_ch.nesting_depth = down_word.nesting_depth;

endmodule

`default_nettype wire
